// ----- rtl/dqb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dqb_pkg
// Shared types, constants and helpers of the DNS query builder.
// ----------------------------------------------------------------------------
package dqb_pkg;

  localparam int unsigned MaxMessageDefault = 512;
  localparam int unsigned MaxLabelDefault   = 63;
  localparam int unsigned QueueDepthDefault = 4;

  localparam int unsigned HeaderLen  = 12;
  localparam logic [7:0]  DotChar    = 8'h2E;
  localparam logic [7:0]  NulChar    = 8'h00;

  // beat index of the back end: 0..11 header, then length/char, then trailer
  localparam logic [4:0] BeatHdrLast = 5'd11;
  localparam logic [4:0] BeatSingle  = 5'd12;
  localparam logic [4:0] BeatTail0   = 5'd13;
  localparam logic [4:0] BeatTailEnd = 5'd17;

  // one queue entry: what the back end has to write for one input beat
  typedef struct packed {
    logic        hdr;         // write the 12-byte header first
    logic [15:0] id;
    logic        single_v;    // one char or label length write
    logic [8:0]  single_off;
    logic [7:0]  single_val;
    logic        tail_v;      // terminator and QTYPE/QCLASS
    logic [9:0]  tail_len;    // total length; trailer sits at tail_len-5
    logic        err;
  } cmd_t;

  function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [15:0] id);
    logic [7:0] b;
    b = 8'h00;
    unique case (idx)
      4'd0:    b = id[7:0];
      4'd1:    b = id[15:8];
      4'd2:    b = 8'h01;
      4'd5:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/dqb_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dqb_front
// Takes name characters, tracks label position and count, queues write jobs.
// ----------------------------------------------------------------------------
module dqb_front #(
  parameter int unsigned MAX_MESSAGE = dqb_pkg::MaxMessageDefault,
  parameter int unsigned MAX_LABEL   = dqb_pkg::MaxLabelDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          mode_i,
  input  wire logic [7:0]    char_i,
  input  wire logic [15:0]   id_i,
  input  wire logic          full_i,
  output logic               push_o,
  output dqb_pkg::cmd_t      cmd_o
);

  localparam int unsigned LW = $clog2(MAX_MESSAGE + 1);
  localparam int unsigned SW = (LW > 10) ? LW : 10;
  localparam int unsigned CW = SW + 1;
  localparam logic [CW-1:0] MaxC = CW'(MAX_MESSAGE);
  localparam logic [SW-1:0] HdrC = SW'(dqb_pkg::HeaderLen);

  logic          open_q, open_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [5:0]    count_q, count_d;
  logic          err_q, err_d;

  logic          first, is_end, accept;
  logic [SW-1:0] base;
  logic [5:0]    cnt;
  logic [CW-1:0] cnt_w, next, pos, s_end, len_end;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    first   = !open_q;
    base    = first ? HdrC : slot_q;
    cnt     = first ? 6'd0 : count_q;
    cnt_w   = CW'(cnt);
    is_end  = mode_i | (char_i == dqb_pkg::NulChar);
    next    = CW'(base) + cnt_w + CW'(1);
    pos     = next;
    s_end   = CW'(base) + ((cnt != 6'd0) ? cnt_w + CW'(1) : CW'(0));
    len_end = s_end + CW'(5);

    open_d  = 1'b1;
    slot_d  = base;
    count_d = cnt;
    err_d   = first ? 1'b0 : err_q;

    cmd_o            = '0;
    cmd_o.hdr        = first;
    cmd_o.id         = id_i;
    cmd_o.single_off = base[8:0];
    cmd_o.single_val = {2'b00, cnt};

    if (is_end) begin
      cmd_o.single_v = (cnt != 6'd0);
      cmd_o.tail_v   = 1'b1;
      cmd_o.tail_len = len_end[9:0];
      open_d         = 1'b0;
      slot_d         = HdrC;
      count_d        = 6'd0;
    end else if (char_i == dqb_pkg::DotChar) begin
      if (next + CW'(5) > MaxC) begin
        err_d = 1'b1;
      end else begin
        cmd_o.single_v = 1'b1;
        slot_d         = next[SW-1:0];
        count_d        = 6'd0;
      end
    end else begin
      if ((cnt >= 6'(MAX_LABEL)) || (pos + CW'(6) > MaxC)) begin
        err_d = 1'b1;
      end else begin
        cmd_o.single_v   = 1'b1;
        cmd_o.single_off = pos[8:0];
        cmd_o.single_val = char_i;
        count_d          = cnt + 6'd1;
      end
    end
    cmd_o.err = err_d;
  end

  // a dropped character or dot with nothing else to do queues no job
  assign push_o = accept & (first | cmd_o.single_v | is_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      slot_q  <= HdrC;
      count_q <= 6'd0;
      err_q   <= 1'b0;
    end else if (accept) begin
      open_q  <= open_d;
      slot_q  <= slot_d;
      count_q <= count_d;
      err_q   <= err_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/dqb_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dqb_queue
// Small job queue between front and back end.
// ----------------------------------------------------------------------------
module dqb_queue #(
  parameter int unsigned DEPTH = dqb_pkg::QueueDepthDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire dqb_pkg::cmd_t wdata_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               avail_o,
  output dqb_pkg::cmd_t      rdata_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  dqb_pkg::cmd_t mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [NW-1:0] num_q;

  assign full_o  = (num_q == NW'(DEPTH));
  assign avail_o = (num_q != '0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      num_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        num_q <= num_q + NW'(1);
      end else if (!push_i && pop_i) begin
        num_q <= num_q - NW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/dqb_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dqb_back
// Expands queued jobs into byte writes, one beat per cycle, output register.
// ----------------------------------------------------------------------------
module dqb_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          avail_i,
  input  wire dqb_pkg::cmd_t cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [8:0]         out_off_o,
  output logic [7:0]         out_val_o,
  output logic               out_last_o,
  output logic [9:0]         out_len_o,
  output logic               out_err_o
);

  logic       started_q;
  logic [4:0] idx_q;
  logic [4:0] cur, nxt;
  logic       done, fire;
  logic [2:0] ti;
  logic [9:0] toff;
  logic [8:0] b_off;
  logic [7:0] b_val;
  logic       b_last;
  logic [9:0] b_len;

  logic       valid_q;
  logic [8:0] off_q;
  logic [7:0] val_q;
  logic       last_q;
  logic [9:0] len_q;
  logic       err_q;

  always_comb begin
    if (started_q) begin
      cur = idx_q;
    end else if (cmd_i.hdr) begin
      cur = 5'd0;
    end else if (cmd_i.single_v) begin
      cur = dqb_pkg::BeatSingle;
    end else begin
      cur = dqb_pkg::BeatTail0;
    end

    nxt  = cur + 5'd1;
    done = 1'b0;
    priority if (cur < dqb_pkg::BeatHdrLast) begin
      done = 1'b0;
    end else if (cur == dqb_pkg::BeatHdrLast) begin
      if (cmd_i.single_v) begin
        nxt = dqb_pkg::BeatSingle;
      end else if (cmd_i.tail_v) begin
        nxt = dqb_pkg::BeatTail0;
      end else begin
        done = 1'b1;
      end
    end else if (cur == dqb_pkg::BeatSingle) begin
      done = !cmd_i.tail_v;
    end else begin
      done = (cur >= dqb_pkg::BeatTailEnd);
    end

    // trailer: terminator, QTYPE 0,1, QCLASS 0,1
    ti     = 3'(cur - dqb_pkg::BeatTail0);
    toff   = cmd_i.tail_len + 10'(ti) - 10'd5;
    b_last = 1'b0;
    b_len  = 10'd0;
    priority if (cur <= dqb_pkg::BeatHdrLast) begin
      b_off = 9'(cur);
      b_val = dqb_pkg::hdr_byte(cur[3:0], cmd_i.id);
    end else if (cur == dqb_pkg::BeatSingle) begin
      b_off = cmd_i.single_off;
      b_val = cmd_i.single_val;
    end else begin
      b_off  = toff[8:0];
      b_val  = ((ti == 3'd2) || (ti == 3'd4)) ? 8'h01 : 8'h00;
      b_last = (ti == 3'd4);
      b_len  = (ti == 3'd4) ? cmd_i.tail_len : 10'd0;
    end
  end

  assign fire  = avail_i & (!valid_q | out_ready_i);
  assign pop_o = fire & done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      idx_q     <= 5'd0;
      valid_q   <= 1'b0;
    end else begin
      if (fire) begin
        started_q <= !done;
        idx_q     <= nxt;
      end
      valid_q <= fire | (valid_q & !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      off_q  <= b_off;
      val_q  <= b_val;
      last_q <= b_last;
      len_q  <= b_len;
      err_q  <= cmd_i.err;
    end
  end

  assign out_valid_o = valid_q;
  assign out_off_o   = off_q;
  assign out_val_o   = val_q;
  assign out_last_o  = last_q;
  assign out_len_o   = len_q;
  assign out_err_o   = err_q;

endmodule
`default_nettype wire

// ----- rtl/dns_query_builder.sv -----
`default_nettype none
// Path: an item's beats pass the job queue, then the output register, to m_axis.
// Throughput: a write beat per cycle unless m_axis stalls, an input beat per cycle
//   while the job queue has room. Each item's k writes (k <= 17) hold the expander.
// Reset: asynchronous, clears name state, job queue and output register;
//   no clearing pass, ready for input straight after reset.
// ----------------------------------------------------------------------------
// dns_query_builder
// Encodes a dotted domain name into a DNS query message as byte writes.
// ----------------------------------------------------------------------------
module dns_query_builder #(
  parameter int unsigned MAX_MESSAGE = dqb_pkg::MaxMessageDefault,
  parameter int unsigned MAX_LABEL   = dqb_pkg::MaxLabelDefault,
  parameter int unsigned QUEUE_DEPTH = dqb_pkg::QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // name_char[7:0], query_id[23:8]
  input  wire logic        s_axis_tuser,  // mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // write_offset[8:0], write_value[16:9], message_length[26:17],
  // overflow_error[27], zero[31:28]
  output logic [31:0]      m_axis_tdata,
  output logic             m_axis_tlast   // run_last
);

  logic          push, full, pop, avail;
  dqb_pkg::cmd_t wcmd, rcmd;
  logic [8:0]    off;
  logic [7:0]    val;
  logic [9:0]    len;
  logic          err;

  dqb_front #(
    .MAX_MESSAGE (MAX_MESSAGE),
    .MAX_LABEL   (MAX_LABEL)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .mode_i     (s_axis_tuser),
    .char_i     (s_axis_tdata[7:0]),
    .id_i       (s_axis_tdata[23:8]),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (wcmd)
  );

  dqb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wcmd),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .rdata_o (rcmd)
  );

  dqb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (avail),
    .cmd_i       (rcmd),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_off_o   (off),
    .out_val_o   (val),
    .out_last_o  (m_axis_tlast),
    .out_len_o   (len),
    .out_err_o   (err)
  );

  assign m_axis_tdata = {4'b0000, err, len, val, off};

endmodule
`default_nettype wire
